/* design/lens_distortion_normalize_top_defines.svh */
`ifndef LENS_DISTORTION_NORMALIZE_TOP_DEFINES_SVH
`define LENS_DISTORTION_NORMALIZE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LDN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LDN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ldn_pkg.sv */
`timescale 1ns / 1ps

package ldn_pkg;

  localparam int COORD_BITS  = 12;
  localparam int CENTER_FRAC = 8;
  localparam int FOCAL_W     = 24;
  localparam int CENTER_W    = 20;
  localparam int COEF_W      = 24;
  localparam int OUT_W       = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int REG_IDX_W   = 3;

  localparam int NORM_LAT = OUT_W + 3;
  localparam int DIST_LAT = 11;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_P1       = 3'd6,
    REG_P2       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] dist_x;
    logic signed [OUT_W-1:0] dist_y;
    logic                    overflow;
  } result_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] p1;
    logic signed [COEF_W-1:0] p2;
  } coef_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] val;
    logic                    ovf;
  } sat_t;

  function automatic logic signed [63:0] ext64(input logic signed [OUT_W-1:0] v);
    return {{(64-OUT_W){v[OUT_W-1]}}, v};
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.val = OUT_MAX;
      r.ovf = 1'b1;
    end else if (v < SAT_LO) begin
      r.val = OUT_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = v[OUT_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

/* design/ldn_norm.sv */
`timescale 1ns / 1ps
`include "lens_distortion_normalize_top_defines.svh"

module ldn_norm #(
  parameter int FRAC_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_vld,
  input  logic [ldn_pkg::COORD_BITS-1:0]  pix,
  input  logic [ldn_pkg::CENTER_W-1:0]    center,
  input  logic [ldn_pkg::FOCAL_W-1:0]     focal,
  output logic                            out_vld,
  output ldn_pkg::sat_t                   res
);

  localparam int PIX_W = ldn_pkg::COORD_BITS + ldn_pkg::CENTER_FRAC;
  localparam int MAG_W = (PIX_W > ldn_pkg::CENTER_W) ? PIX_W : ldn_pkg::CENTER_W;
  localparam int DIV_W = MAG_W + FRAC_BITS + 1;
  localparam int QW    = ldn_pkg::OUT_W;
  localparam int STEPS = ldn_pkg::OUT_W;
  localparam int FW    = ldn_pkg::FOCAL_W;

  typedef struct packed {
    logic neg;
    logic zero;
    logic big;
  } side_t;

  // offset from principal point
  logic signed [MAG_W:0] diff;
  logic        [MAG_W:0] diff_neg;
  logic [MAG_W-1:0]      mag_a;
  logic                  neg_a;
  logic                  vld_a;

  assign diff = $signed({1'b0, MAG_W'({pix, {ldn_pkg::CENTER_FRAC{1'b0}}})})
              - $signed({1'b0, MAG_W'(center)});
  assign diff_neg = -diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    mag_a <= diff[MAG_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    neg_a <= diff[MAG_W];
  end

  // dividend and quotient range check
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] hi;

  assign dvd = DIV_W'({mag_a, {FRAC_BITS{1'b0}}}) + DIV_W'(focal >> 1);
  assign hi  = dvd >> QW;

  logic [FW-1:0] rem_s  [0:STEPS-1];
  logic [QW-1:0] low_s  [0:STEPS-1];
  logic [QW-1:0] quo_s  [0:STEPS];
  side_t         side_s [0:STEPS];
  logic          vld_s  [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else begin
      vld_s[0] <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    rem_s[0]       <= FW'(hi);
    low_s[0]       <= dvd[QW-1:0];
    quo_s[0]       <= '0;
    side_s[0].neg  <= neg_a;
    side_s[0].zero <= (mag_a == '0);
    side_s[0].big  <= (hi >= DIV_W'(focal));
  end

  // one quotient bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_div
    logic [FW:0] trial;
    logic        ge;

    assign trial     = {rem_s[k], low_s[k][QW-1]};
    assign ge        = (trial >= {1'b0, focal});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
      side_s[k+1] <= side_s[k];
    end

    if (k < STEPS - 1) begin : g_carry
      logic [FW:0] trial_sub;

      assign trial_sub = trial - {1'b0, focal};

      always_ff @(posedge clk) begin
        rem_s[k+1] <= ge ? trial_sub[FW-1:0] : trial[FW-1:0];
        low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
      end
    end
  end

  // sign and saturation
  logic [QW-1:0] q_fin;
  side_t         side_fin;

  assign q_fin    = quo_s[STEPS];
  assign side_fin = side_s[STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld_s[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (side_fin.zero) begin
      res.val <= '0;
      res.ovf <= 1'b0;
    end else if (side_fin.big) begin
      res.val <= side_fin.neg ? ldn_pkg::OUT_MIN : ldn_pkg::OUT_MAX;
      res.ovf <= 1'b1;
    end else if (side_fin.neg) begin
      if (q_fin > {1'b1, {(QW-1){1'b0}}}) begin
        res.val <= ldn_pkg::OUT_MIN;
        res.ovf <= 1'b1;
      end else begin
        res.val <= $signed(QW'(0) - q_fin);
        res.ovf <= 1'b0;
      end
    end else begin
      if (q_fin[QW-1]) begin
        res.val <= ldn_pkg::OUT_MAX;
        res.ovf <= 1'b1;
      end else begin
        res.val <= $signed(q_fin);
        res.ovf <= 1'b0;
      end
    end
  end

  `LDN_ASSERT_IMPL(a_norm_sat_bound, clk, rst, out_vld && res.ovf, (res.val == ldn_pkg::OUT_MAX || res.val == ldn_pkg::OUT_MIN), "saturated normalize not at a bound")
  `LDN_ASSERT_NEXT(a_norm_zero, clk, rst, vld_s[STEPS] && side_fin.zero, (res.val == '0 && !res.ovf), "zero offset did not give zero")

endmodule

/* design/ldn_mulq.sv */
`timescale 1ns / 1ps

module ldn_mulq #(
  parameter int FRAC_BITS = 20
) (
  input  logic                              clk,
  input  logic signed [ldn_pkg::OUT_W-1:0]  a,
  input  logic signed [ldn_pkg::OUT_W-1:0]  b,
  output ldn_pkg::sat_t                     res
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prod;
  logic signed [63:0] biased;
  logic signed [63:0] shifted;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // round half away from zero
  assign biased  = prod + (prod[63] ? (HALF - 64'sd1) : HALF);
  assign shifted = biased >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    res <= ldn_pkg::sat32(shifted);
  end

endmodule

/* design/ldn_distort.sv */
`timescale 1ns / 1ps
`include "lens_distortion_normalize_top_defines.svh"

module ldn_distort #(
  parameter int FRAC_BITS = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  ldn_pkg::sat_t    nx,
  input  ldn_pkg::sat_t    ny,
  input  ldn_pkg::coef_t   coef,
  output logic             out_vld,
  output ldn_pkg::result_t result
);

  localparam int LAST = ldn_pkg::DIST_LAT;
  localparam int W    = ldn_pkg::OUT_W;
  localparam int EXT  = ldn_pkg::OUT_W - ldn_pkg::COEF_W;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  logic signed [W-1:0] k1;
  logic signed [W-1:0] k2;
  logic signed [W-1:0] p1;
  logic signed [W-1:0] p2;

  assign k1 = {{EXT{coef.k1[ldn_pkg::COEF_W-1]}}, coef.k1};
  assign k2 = {{EXT{coef.k2[ldn_pkg::COEF_W-1]}}, coef.k2};
  assign p1 = {{EXT{coef.p1[ldn_pkg::COEF_W-1]}}, coef.p1};
  assign p2 = {{EXT{coef.p2[ldn_pkg::COEF_W-1]}}, coef.p2};

  // valid and running overflow per beat
  logic [LAST-1:0] vld_sr;
  logic [LAST-1:0] flag_sr;
  logic [LAST-1:0] flags_at;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
    end else begin
      vld_sr <= {vld_sr[LAST-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    flag_sr <= {flag_sr[LAST-2:0], nx.ovf | ny.ovf} | flags_at;
  end

  logic signed [W-1:0] x_sr [1:LAST];
  logic signed [W-1:0] y_sr [1:LAST];

  always_ff @(posedge clk) begin
    x_sr[1] <= nx.val;
    y_sr[1] <= ny.val;
    for (int i = 2; i <= LAST; i++) begin
      x_sr[i] <= x_sr[i-1];
      y_sr[i] <= y_sr[i-1];
    end
  end

  // squares and cross term
  ldn_pkg::sat_t xx, yy, xy;

  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_xx (.clk(clk), .a(nx.val), .b(nx.val), .res(xx));
  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_yy (.clk(clk), .a(ny.val), .b(ny.val), .res(yy));
  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_xy (.clk(clk), .a(nx.val), .b(ny.val), .res(xy));

  ldn_pkg::sat_t       r2;
  logic signed [W-1:0] xx_d;
  logic signed [W-1:0] yy_d;

  always_ff @(posedge clk) begin
    r2   <= ldn_pkg::sat32(ldn_pkg::ext64(xx.val) + ldn_pkg::ext64(yy.val));
    xx_d <= xx.val;
    yy_d <= yy.val;
  end

  ldn_pkg::sat_t tx, ty;

  always_ff @(posedge clk) begin
    tx <= ldn_pkg::sat32(ldn_pkg::ext64(r2.val) + (ldn_pkg::ext64(xx_d) <<< 1));
    ty <= ldn_pkg::sat32(ldn_pkg::ext64(r2.val) + (ldn_pkg::ext64(yy_d) <<< 1));
  end

  // radial polynomial
  ldn_pkg::sat_t r4, k1r2, k2r4;

  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_r4   (.clk(clk), .a(r2.val), .b(r2.val), .res(r4));
  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_k1r2 (.clk(clk), .a(k1), .b(r2.val), .res(k1r2));
  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_k2r4 (.clk(clk), .a(k2), .b(r4.val), .res(k2r4));

  logic signed [W-1:0] k1r2_sr [1:2];

  always_ff @(posedge clk) begin
    k1r2_sr[1] <= k1r2.val;
    k1r2_sr[2] <= k1r2_sr[1];
  end

  ldn_pkg::sat_t radial;

  always_ff @(posedge clk) begin
    radial <= ldn_pkg::sat32(ONE + ldn_pkg::ext64(k1r2_sr[2]) + ldn_pkg::ext64(k2r4.val));
  end

  ldn_pkg::sat_t rx, ry;

  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_rx (.clk(clk), .a(radial.val), .b(x_sr[8]), .res(rx));
  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_ry (.clk(clk), .a(radial.val), .b(y_sr[8]), .res(ry));

  // tangential terms
  ldn_pkg::sat_t p1xy, p2xy, p2tx, p1ty;

  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_p1xy (.clk(clk), .a(p1), .b(xy.val), .res(p1xy));
  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_p2xy (.clk(clk), .a(p2), .b(xy.val), .res(p2xy));
  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_p2tx (.clk(clk), .a(p2), .b(tx.val), .res(p2tx));
  ldn_mulq #(.FRAC_BITS(FRAC_BITS)) u_p1ty (.clk(clk), .a(p1), .b(ty.val), .res(p1ty));

  logic signed [W-1:0] p1xy_sr [1:6];
  logic signed [W-1:0] p2xy_sr [1:6];
  logic signed [W-1:0] p2tx_sr [1:4];
  logic signed [W-1:0] p1ty_sr [1:4];

  always_ff @(posedge clk) begin
    p1xy_sr[1] <= p1xy.val;
    p2xy_sr[1] <= p2xy.val;
    for (int i = 2; i <= 6; i++) begin
      p1xy_sr[i] <= p1xy_sr[i-1];
      p2xy_sr[i] <= p2xy_sr[i-1];
    end
    p2tx_sr[1] <= p2tx.val;
    p1ty_sr[1] <= p1ty.val;
    for (int i = 2; i <= 4; i++) begin
      p2tx_sr[i] <= p2tx_sr[i-1];
      p1ty_sr[i] <= p1ty_sr[i-1];
    end
  end

  ldn_pkg::sat_t dx, dy;

  always_ff @(posedge clk) begin
    dx <= ldn_pkg::sat32(ldn_pkg::ext64(rx.val) + (ldn_pkg::ext64(p1xy_sr[6]) <<< 1)
                         + ldn_pkg::ext64(p2tx_sr[4]));
    dy <= ldn_pkg::sat32(ldn_pkg::ext64(ry.val) + ldn_pkg::ext64(p1ty_sr[4])
                         + (ldn_pkg::ext64(p2xy_sr[6]) <<< 1));
  end

  // overflow sources by the cycle they appear in
  always_comb begin
    flags_at     = '0;
    flags_at[2]  = xx.ovf | yy.ovf | xy.ovf;
    flags_at[3]  = r2.ovf;
    flags_at[4]  = tx.ovf | ty.ovf | p1xy.ovf | p2xy.ovf;
    flags_at[5]  = r4.ovf | k1r2.ovf;
    flags_at[6]  = p2tx.ovf | p1ty.ovf;
    flags_at[7]  = k2r4.ovf;
    flags_at[8]  = radial.ovf;
    flags_at[10] = rx.ovf | ry.ovf;
  end

  assign out_vld         = vld_sr[LAST-1];
  assign result.norm_x   = x_sr[LAST];
  assign result.norm_y   = y_sr[LAST];
  assign result.dist_x   = dx.val;
  assign result.dist_y   = dy.val;
  assign result.overflow = flag_sr[LAST-1] | dx.ovf | dy.ovf;

  `LDN_ASSERT_IMPL(a_dist_vld_align, clk, rst, out_vld, $past(in_vld, LAST), "valid out of step with pipeline depth")
  `LDN_ASSERT_IMPL(a_dist_identity, clk, rst, out_vld && coef.k1 == '0 && coef.k2 == '0 && coef.p1 == '0 && coef.p2 == '0, (result.dist_x == result.norm_x && result.dist_y == result.norm_y), "zero coefficients changed the point")

endmodule

/* design/lens_distortion_normalize_top.sv */
// throughput: one point per clock, set by the fully pipelined divider and multipliers
// results show for a single cycle on done; the receiver cannot stall
// reset clears all pipeline valid bits and loads focal 1.0, all other registers 0
// busy is high only during reset
`timescale 1ns / 1ps
`include "lens_distortion_normalize_top_defines.svh"

module lens_distortion_normalize_top #(
  parameter int FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ldn_pkg::point_t               point,
  output logic                          done,
  output ldn_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ldn_pkg::ADDR_W-1:0]    paddr,
  input  logic [ldn_pkg::DATA_W-1:0]    pwdata,
  output logic [ldn_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int LAT = ldn_pkg::NORM_LAT + ldn_pkg::DIST_LAT;
  localparam int DW  = ldn_pkg::DATA_W;

  logic [ldn_pkg::FOCAL_W-1:0]         focal_x;
  logic [ldn_pkg::FOCAL_W-1:0]         focal_y;
  logic [ldn_pkg::CENTER_W-1:0]        center_x;
  logic [ldn_pkg::CENTER_W-1:0]        center_y;
  logic signed [ldn_pkg::COEF_W-1:0]   radial_k1;
  logic signed [ldn_pkg::COEF_W-1:0]   radial_k2;
  logic signed [ldn_pkg::COEF_W-1:0]   tangential_p1;
  logic signed [ldn_pkg::COEF_W-1:0]   tangential_p2;

  ldn_pkg::reg_idx_t reg_idx;
  logic              reg_wr;

  assign reg_idx = ldn_pkg::reg_idx_t'(paddr[ldn_pkg::ADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x       <= ldn_pkg::FOCAL_W'(256);
      focal_y       <= ldn_pkg::FOCAL_W'(256);
      center_x      <= '0;
      center_y      <= '0;
      radial_k1     <= '0;
      radial_k2     <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        ldn_pkg::REG_FOCAL_X:  focal_x       <= pwdata[ldn_pkg::FOCAL_W-1:0];
        ldn_pkg::REG_FOCAL_Y:  focal_y       <= pwdata[ldn_pkg::FOCAL_W-1:0];
        ldn_pkg::REG_CENTER_X: center_x      <= pwdata[ldn_pkg::CENTER_W-1:0];
        ldn_pkg::REG_CENTER_Y: center_y      <= pwdata[ldn_pkg::CENTER_W-1:0];
        ldn_pkg::REG_K1:       radial_k1     <= pwdata[ldn_pkg::COEF_W-1:0];
        ldn_pkg::REG_K2:       radial_k2     <= pwdata[ldn_pkg::COEF_W-1:0];
        ldn_pkg::REG_P1:       tangential_p1 <= pwdata[ldn_pkg::COEF_W-1:0];
        ldn_pkg::REG_P2:       tangential_p2 <= pwdata[ldn_pkg::COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ldn_pkg::REG_FOCAL_X:  prdata = {{(DW-ldn_pkg::FOCAL_W){1'b0}}, focal_x};
      ldn_pkg::REG_FOCAL_Y:  prdata = {{(DW-ldn_pkg::FOCAL_W){1'b0}}, focal_y};
      ldn_pkg::REG_CENTER_X: prdata = {{(DW-ldn_pkg::CENTER_W){1'b0}}, center_x};
      ldn_pkg::REG_CENTER_Y: prdata = {{(DW-ldn_pkg::CENTER_W){1'b0}}, center_y};
      ldn_pkg::REG_K1:       prdata = {{(DW-ldn_pkg::COEF_W){1'b0}}, radial_k1};
      ldn_pkg::REG_K2:       prdata = {{(DW-ldn_pkg::COEF_W){1'b0}}, radial_k2};
      ldn_pkg::REG_P1:       prdata = {{(DW-ldn_pkg::COEF_W){1'b0}}, tangential_p1};
      ldn_pkg::REG_P2:       prdata = {{(DW-ldn_pkg::COEF_W){1'b0}}, tangential_p2};
      default:               prdata = '0;
    endcase
  end

  // input beat
  logic in_vld;

  assign busy   = rst;
  assign in_vld = start && !busy;

  ldn_pkg::sat_t  nx;
  ldn_pkg::sat_t  ny;
  logic           norm_vld;
  logic           norm_vld_y;
  ldn_pkg::coef_t coef;

  assign coef.k1 = radial_k1;
  assign coef.k2 = radial_k2;
  assign coef.p1 = tangential_p1;
  assign coef.p2 = tangential_p2;

  ldn_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_x (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (in_vld),
    .pix     (point.pixel_x),
    .center  (center_x),
    .focal   (focal_x),
    .out_vld (norm_vld),
    .res     (nx)
  );

  ldn_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_y (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (in_vld),
    .pix     (point.pixel_y),
    .center  (center_y),
    .focal   (focal_y),
    .out_vld (norm_vld_y),
    .res     (ny)
  );

  ldn_distort #(.FRAC_BITS(FRAC_BITS)) u_distort (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (norm_vld && norm_vld_y),
    .nx      (nx),
    .ny      (ny),
    .coef    (coef),
    .out_vld (done),
    .result  (result)
  );

  `LDN_ASSERT_IMPL(a_top_latency, clk, rst, done, $past(start && !busy, LAT), "done without a start beat at the fixed latency")

endmodule
